// File: sv/cnp_pkg.sv
// Package for the complex-number text parser: token and result types,
// character codes and size constants. No dependencies.
package cnp_pkg;

	localparam int MAX_DIGITS = 18;
	localparam int ACC_W      = 60;
	localparam int CNT_W      = 5;
	localparam int MANT_W     = 61;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_MINUS,
		TK_PLUS,
		TK_DOT,
		TK_I,
		TK_NUL,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t            kind;
		logic [DIGIT_W-1:0]   digit;
		logic                 last;
	} tok_t;

	typedef enum logic [1:0] {
		PH_REAL,
		PH_IMAG,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [ACC_W-1:0] real_acc;
		logic             real_neg;
		logic [CNT_W-1:0] real_cnt;
		logic [ACC_W-1:0] imag_acc;
		logic             imag_neg;
		logic [CNT_W-1:0] imag_cnt;
		logic             ovf;
	} res_t;

endpackage

// File: sv/cnp_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on cnp_pkg.
module cnp_front import cnp_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last,
	input  logic              char_valid,
	output logic              char_ready,
	input  logic              fifo_full,
	output logic              push,
	output tok_t              tok
);

	logic is_digit;
	logic [CHAR_W-1:0] diff;

	assign char_ready = !fifo_full;
	assign push       = char_valid && !fifo_full;
	assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign diff       = char_code - CH_ZERO;

	always_comb begin
		tok.last  = last;
		tok.digit = diff[DIGIT_W-1:0];
		if (is_digit) begin
			tok.kind = TK_DIGIT;
		end else if (char_code == CH_MINUS) begin
			tok.kind = TK_MINUS;
		end else if (char_code == CH_PLUS) begin
			tok.kind = TK_PLUS;
		end else if (char_code == CH_DOT) begin
			tok.kind = TK_DOT;
		end else if (char_code == CH_I) begin
			tok.kind = TK_I;
		end else if (char_code == CH_NUL) begin
			tok.kind = TK_NUL;
		end else begin
			tok.kind = TK_OTHER;
		end
	end

endmodule

// File: sv/cnp_fifo.sv
// Token queue between the front end and the parser core.
// Depends on cnp_pkg.
module cnp_fifo import cnp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic avail,
	output tok_t pop_tok
);

	tok_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FCNT_W'(FIFO_DEPTH));
	assign avail   = (cnt_q != '0);
	assign pop_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/cnp_back.sv
// Parser core: runs the real/imaginary part state machine on tokens and
// captures the result as magnitudes and sign flags on the last token. Depends on cnp_pkg.
module cnp_back import cnp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  tok_t tok,
	output logic pop,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	phase_t           phase_q, phase_n;
	logic             at_start_q, at_start_n;
	logic             stopped_q, stopped_n;
	logic             frac_q, frac_n;
	logic             lminus_q, lminus_n;
	logic             prev_minus_q, prev_minus_n;
	logic [ACC_W-1:0] real_acc_q, real_acc_n;
	logic [CNT_W-1:0] real_cnt_q, real_cnt_n;
	logic             real_neg_q, real_neg_n;
	logic [ACC_W-1:0] imag_acc_q, imag_acc_n;
	logic [CNT_W-1:0] imag_cnt_q, imag_cnt_n;
	logic             flip_q, flip_n;
	logic [CNT_W-1:0] dtotal_q, dtotal_n;
	logic             ovf_q, ovf_n;

	logic             in_imag;
	logic [ACC_W-1:0] cur_acc;
	logic [CNT_W-1:0] cur_cnt;
	logic [ACC_W-1:0] acc_x10;
	logic             skip;
	logic             res_v_q;
	res_t             res_s1;
	res_t             res_n;
	logic             s1_free;

	assign in_imag = (phase_q == PH_IMAG);
	assign cur_acc = in_imag ? imag_acc_q : real_acc_q;
	assign cur_cnt = in_imag ? imag_cnt_q : real_cnt_q;
	assign acc_x10 = (cur_acc << 3) + (cur_acc << 1) + ACC_W'(tok.digit);

	assign s1_free   = !res_v_q || res_ready;
	assign pop       = avail && (!tok.last || s1_free);
	assign res_valid = res_v_q;
	assign res       = res_s1;

	always_comb begin
		phase_n = phase_q;
		if (phase_q != PH_DONE) begin
			if (tok.kind == TK_NUL) begin
				phase_n = PH_DONE;
			end else if (phase_q == PH_REAL && tok.kind == TK_I) begin
				phase_n = PH_IMAG;
			end
		end
	end

	always_comb begin
		at_start_n   = at_start_q;
		stopped_n    = stopped_q;
		frac_n       = frac_q;
		lminus_n     = lminus_q;
		prev_minus_n = prev_minus_q;
		real_acc_n   = real_acc_q;
		real_cnt_n   = real_cnt_q;
		real_neg_n   = real_neg_q;
		imag_acc_n   = imag_acc_q;
		imag_cnt_n   = imag_cnt_q;
		flip_n       = flip_q;
		dtotal_n     = dtotal_q;
		ovf_n        = ovf_q;
		skip         = 1'b0;
		if (phase_q != PH_DONE) begin
			prev_minus_n = (tok.kind == TK_MINUS);
			if (tok.kind == TK_NUL) begin
				if (phase_q == PH_REAL) begin
					real_neg_n = lminus_q;
					lminus_n   = 1'b0;
				end
			end else if (phase_q == PH_REAL && tok.kind == TK_I) begin
				real_neg_n = lminus_q;
				lminus_n   = 1'b0;
				flip_n     = prev_minus_q;
				at_start_n = 1'b1;
				stopped_n  = 1'b0;
				frac_n     = 1'b0;
				dtotal_n   = '0;
			end else begin
				if (at_start_q) begin
					at_start_n = 1'b0;
					if (tok.kind == TK_MINUS) begin
						lminus_n = 1'b1;
						skip     = 1'b1;
					end else if (tok.kind == TK_PLUS) begin
						skip = 1'b1;
					end
				end
				if (!skip && !stopped_q) begin
					if (tok.kind == TK_DIGIT) begin
						if (dtotal_q < CNT_W'(MAX_DIGITS)) begin
							dtotal_n = dtotal_q + CNT_W'(1);
							if (in_imag) begin
								imag_acc_n = acc_x10;
								imag_cnt_n = frac_q ? cur_cnt + CNT_W'(1) : cur_cnt;
							end else begin
								real_acc_n = acc_x10;
								real_cnt_n = frac_q ? cur_cnt + CNT_W'(1) : cur_cnt;
							end
						end else begin
							ovf_n = 1'b1;
						end
					end else if (tok.kind == TK_DOT) begin
						frac_n = 1'b1;
					end else begin
						stopped_n = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res_n.real_acc = real_acc_n;
		res_n.real_cnt = real_cnt_n;
		res_n.real_neg = (phase_n == PH_REAL) ? lminus_n : real_neg_n;
		res_n.imag_acc = imag_acc_n;
		res_n.imag_cnt = imag_cnt_n;
		res_n.imag_neg = ((phase_n == PH_REAL) ? 1'b0 : lminus_n) ^ flip_n;
		res_n.ovf      = ovf_n;
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			res_s1 <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q      <= 1'b0;
			phase_q      <= PH_REAL;
			at_start_q   <= 1'b1;
			stopped_q    <= 1'b0;
			frac_q       <= 1'b0;
			lminus_q     <= 1'b0;
			prev_minus_q <= 1'b0;
			real_acc_q   <= '0;
			real_cnt_q   <= '0;
			real_neg_q   <= 1'b0;
			imag_acc_q   <= '0;
			imag_cnt_q   <= '0;
			flip_q       <= 1'b0;
			dtotal_q     <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (pop && tok.last) begin
				res_v_q <= 1'b1;
			end else if (res_ready) begin
				res_v_q <= 1'b0;
			end
			if (pop) begin
				if (tok.last) begin
					phase_q      <= PH_REAL;
					at_start_q   <= 1'b1;
					stopped_q    <= 1'b0;
					frac_q       <= 1'b0;
					lminus_q     <= 1'b0;
					prev_minus_q <= 1'b0;
					real_acc_q   <= '0;
					real_cnt_q   <= '0;
					real_neg_q   <= 1'b0;
					imag_acc_q   <= '0;
					imag_cnt_q   <= '0;
					flip_q       <= 1'b0;
					dtotal_q     <= '0;
					ovf_q        <= 1'b0;
				end else begin
					phase_q      <= phase_n;
					at_start_q   <= at_start_n;
					stopped_q    <= stopped_n;
					frac_q       <= frac_n;
					lminus_q     <= lminus_n;
					prev_minus_q <= prev_minus_n;
					real_acc_q   <= real_acc_n;
					real_cnt_q   <= real_cnt_n;
					real_neg_q   <= real_neg_n;
					imag_acc_q   <= imag_acc_n;
					imag_cnt_q   <= imag_cnt_n;
					flip_q       <= flip_n;
					dtotal_q     <= dtotal_n;
					ovf_q        <= ovf_n;
				end
			end
		end
	end

endmodule

// File: sv/cnp_out.sv
// Output stage: applies the signs and holds the result until it is taken.
// Depends on cnp_pkg.
module cnp_out import cnp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_valid,
	output logic                     res_ready,
	input  res_t                     res,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [MANT_W-1:0] real_mantissa,
	output logic        [CNT_W-1:0]  real_frac_digits,
	output logic signed [MANT_W-1:0] imag_mantissa,
	output logic        [CNT_W-1:0]  imag_frac_digits,
	output logic                     overflow
);

	logic              valid_q;
	logic [MANT_W-1:0] real_ext;
	logic [MANT_W-1:0] imag_ext;
	logic              load;

	assign res_ready = !valid_q || out_ready;
	assign load      = res_valid && res_ready;
	assign out_valid = valid_q;
	assign real_ext  = {1'b0, res.real_acc};
	assign imag_ext  = {1'b0, res.imag_acc};

	always_ff @(posedge clk) begin
		if (load) begin
			real_mantissa    <= res.real_neg ? -real_ext : real_ext;
			real_frac_digits <= res.real_cnt;
			imag_mantissa    <= res.imag_neg ? -imag_ext : imag_ext;
			imag_frac_digits <= res.imag_cnt;
			overflow         <= res.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

endmodule

// File: sv/complex_number_text_parser.sv
// Complex-number text parser, top level. One character per cycle sustained while
// the result path does not stall. After the last character is accepted, the result
// passes through the token queue, then parser core into result register, then sign stage.
// Throughput: one character per clock, set by the parser core, unless results back up.
// Reset (arst_n low, asynchronous) empties the queue and returns the parser
// to the start of a real part. Depends on cnp_pkg and the cnp_* modules.
module complex_number_text_parser import cnp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CHAR_W-1:0]        char_code,
	input  logic                     last,
	input  logic                     char_valid,
	output logic                     char_ready,
	output logic signed [MANT_W-1:0] real_mantissa,
	output logic        [CNT_W-1:0]  real_frac_digits,
	output logic signed [MANT_W-1:0] imag_mantissa,
	output logic        [CNT_W-1:0]  imag_frac_digits,
	output logic                     overflow,
	output logic                     res_valid,
	input  logic                     res_ready
);

	logic push;
	tok_t push_tok;
	logic fifo_full;
	logic fifo_avail;
	logic pop;
	tok_t pop_tok;
	logic core_valid;
	logic core_ready;
	res_t core_res;

	cnp_front u_front (
		.char_code (char_code),
		.last      (last),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.fifo_full (fifo_full),
		.push      (push),
		.tok       (push_tok)
	);

	cnp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_tok(push_tok),
		.full    (fifo_full),
		.pop     (pop),
		.avail   (fifo_avail),
		.pop_tok (pop_tok)
	);

	cnp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (fifo_avail),
		.tok      (pop_tok),
		.pop      (pop),
		.res_valid(core_valid),
		.res_ready(core_ready),
		.res      (core_res)
	);

	cnp_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.res_valid       (core_valid),
		.res_ready       (core_ready),
		.res             (core_res),
		.out_valid       (res_valid),
		.out_ready       (res_ready),
		.real_mantissa   (real_mantissa),
		.real_frac_digits(real_frac_digits),
		.imag_mantissa   (imag_mantissa),
		.imag_frac_digits(imag_frac_digits),
		.overflow        (overflow)
	);

endmodule

// File: tb/tb_complex_number_text_parser.sv
// Self-checking testbench for complex_number_text_parser: directed texts, then random
// character streams with sender bursts and receiver stalls, checked by a local predictor.
// Depends on cnp_pkg and the parser RTL.
module tb_complex_number_text_parser import cnp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NO_MID         = -1;
	localparam int RANDOM_CHARS   = 890;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_PRINTS     = 60;

	typedef struct packed {
		logic signed [MANT_W-1:0] re_m;
		logic        [CNT_W-1:0]  re_f;
		logic signed [MANT_W-1:0] im_m;
		logic        [CNT_W-1:0]  im_f;
		logic                     ovf;
	} cplx_t;

	typedef struct packed {
		logic  typed;
		cplx_t want;
	} plan_t;

	typedef struct {
		string head;
		int    mid;
		string tail;
		bit    typed;
		cplx_t want;
	} text_row_t;

	localparam cplx_t ZERO_RES = '0;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic [CHAR_W-1:0]        char_code = '0;
	logic                     last = 1'b0;
	logic                     char_valid = 1'b0;
	logic                     char_ready;
	logic signed [MANT_W-1:0] real_mantissa;
	logic        [CNT_W-1:0]  real_frac_digits;
	logic signed [MANT_W-1:0] imag_mantissa;
	logic        [CNT_W-1:0]  imag_frac_digits;
	logic                     overflow;
	logic                     res_valid;
	logic                     res_ready = 1'b0;

	complex_number_text_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_code(char_code),
		.last(last),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.real_mantissa(real_mantissa),
		.real_frac_digits(real_frac_digits),
		.imag_mantissa(imag_mantissa),
		.imag_frac_digits(imag_frac_digits),
		.overflow(overflow),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	always #10 clk = ~clk;

	// parser state mirrored by the predictor
	phase_t           ph;
	bit               at_start, stopped, in_frac, lead_minus, prev_minus;
	bit               re_neg, im_flip, ovf_seen;
	logic [ACC_W-1:0] re_acc, im_acc;
	logic [CNT_W-1:0] re_cnt, im_cnt;
	int               digit_cnt;

	cplx_t             expected_q[$];
	plan_t             plan_q[$];
	logic [CHAR_W-1:0] txt_q[$];
	text_row_t         dir_rows[10];

	int  errors, texts_sent, chars_sent, results_checked, ovf_results;
	int  idle_cycles, burst_left, rx_left, rx_mode;
	bit  quiet, draining;

	cplx_t next_res;
	plan_t next_plan;

	function automatic void start_part();
		at_start   = 1'b1;
		stopped    = 1'b0;
		in_frac    = 1'b0;
		lead_minus = 1'b0;
		digit_cnt  = 0;
	endfunction

	function automatic void clear_parser();
		ph = PH_REAL;
		start_part();
		prev_minus = 1'b0;
		re_acc     = '0;
		re_cnt     = '0;
		re_neg     = 1'b0;
		im_acc     = '0;
		im_cnt     = '0;
		im_flip    = 1'b0;
		ovf_seen   = 1'b0;
	endfunction

	function automatic void close_real();
		re_neg     = lead_minus;
		lead_minus = 1'b0;
	endfunction

	function automatic logic signed [MANT_W-1:0] signed_mant(logic [ACC_W-1:0] acc, bit neg);
		logic signed [MANT_W-1:0] m;
		m = {1'b0, acc};
		return neg ? -m : m;
	endfunction

	function automatic void feed_char(logic [CHAR_W-1:0] c, bit is_imag);
		if (at_start) begin
			at_start = 1'b0;
			if (c == CH_MINUS) begin
				lead_minus = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (stopped)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (digit_cnt < MAX_DIGITS) begin
				if (is_imag)
					im_acc = im_acc * 10 + ACC_W'(c - CH_ZERO);
				else
					re_acc = re_acc * 10 + ACC_W'(c - CH_ZERO);
				digit_cnt++;
				if (in_frac) begin
					if (is_imag)
						im_cnt++;
					else
						re_cnt++;
				end
			end else begin
				ovf_seen = 1'b1;
			end
		end else if (c == CH_DOT) begin
			in_frac = 1'b1;
		end else begin
			stopped = 1'b1;
		end
	endfunction

	function automatic bit parse_char(logic [CHAR_W-1:0] c, logic is_last, output cplx_t r);
		r = ZERO_RES;
		if (ph != PH_DONE) begin
			if (c == CH_NUL) begin
				if (ph == PH_REAL)
					close_real();
				ph = PH_DONE;
			end else if (ph == PH_REAL && c == CH_I) begin
				close_real();
				im_flip = prev_minus;
				ph = PH_IMAG;
				start_part();
			end else begin
				feed_char(c, ph == PH_IMAG);
			end
			prev_minus = (c == CH_MINUS);
		end
		if (!is_last)
			return 1'b0;
		if (ph == PH_REAL)
			close_real();
		r.re_m = signed_mant(re_acc, re_neg);
		r.re_f = re_cnt;
		r.im_m = signed_mant(im_acc, lead_minus != im_flip);
		r.im_f = im_cnt;
		r.ovf  = ovf_seen;
		clear_parser();
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch on %s at result %0d: want %0d, got %0d",
				what, results_checked, want, got);
	endtask

	task automatic check_result(cplx_t want);
		if (real_mantissa !== want.re_m)
			report_mismatch("real_mantissa", want.re_m, real_mantissa);
		if (real_frac_digits !== want.re_f)
			report_mismatch("real_frac_digits", want.re_f, real_frac_digits);
		if (imag_mantissa !== want.im_m)
			report_mismatch("imag_mantissa", want.im_m, imag_mantissa);
		if (imag_frac_digits !== want.im_f)
			report_mismatch("imag_frac_digits", want.im_f, imag_frac_digits);
		if (overflow !== want.ovf)
			report_mismatch("overflow", want.ovf, overflow);
		if (want.ovf)
			ovf_results++;
		results_checked++;
	endtask

	// random character generation
	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 7))
			0: return CH_NUL;
			1: return CH_I;
			2: return CH_MINUS;
			3: return CH_DOT;
			4: return CH_PLUS;
			5: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_digits();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
		repeat (n) txt_q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
	endfunction

	function automatic void add_number();
		case ($urandom_range(0, 3))
			0: txt_q.push_back(CH_MINUS);
			1: txt_q.push_back(CH_PLUS);
			default: ;
		endcase
		add_digits();
		if ($urandom_range(0, 2) == 0) begin
			txt_q.push_back(CH_DOT);
			if ($urandom_range(0, 5) == 0)
				txt_q.push_back(CH_DOT);
			add_digits();
		end
	endfunction

	function automatic void build_text();
		int kind;
		txt_q.delete();
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			repeat ($urandom_range(1, 6)) txt_q.push_back(pick_char());
		end else begin
			add_number();
			if ($urandom_range(0, 5) != 0) begin
				case ($urandom_range(0, 2))
					0: txt_q.push_back(CH_PLUS);
					1: txt_q.push_back(CH_MINUS);
					default: ;
				endcase
				txt_q.push_back(CH_I);
				add_number();
			end
			if (kind < 6)
				txt_q.insert($urandom_range(0, txt_q.size()), pick_char());
		end
		if (txt_q.size() == 0)
			txt_q.push_back(pick_char());
	endfunction

	// drive one character; called at a rising edge, returns at the accepting edge
	task automatic put_char(logic [CHAR_W-1:0] c, logic is_last);
		int gap;
		if ($urandom_range(0, 149) == 0)
			quiet = !quiet;
		if (burst_left == 0) begin
			gap = quiet ? 0 : $urandom_range(0, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		char_valid <= 1'b1;
		char_code <= c;
		last <= is_last;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_text(bit typed, cplx_t want);
		plan_q.push_back('{typed, want});
		foreach (txt_q[k])
			put_char(txt_q[k], k == txt_q.size() - 1);
		texts_sent++;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (draining) begin
			res_ready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= 1'($urandom_range(0, 1));
				2: res_ready <= ($urandom_range(0, 3) == 0);
				default: res_ready <= (rx_left % 8 == 0);
			endcase
		end
	end

	// predict on accepted characters, compare accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (char_valid && char_ready) begin
				idle_cycles = 0;
				if (parse_char(char_code, last, next_res)) begin
					next_plan = plan_q.pop_front();
					expected_q.push_back(next_plan.typed ? next_plan.want : next_res);
				end
			end
			if (res_valid && res_ready) begin
				idle_cycles = 0;
				if (expected_q.size() == 0)
					report_mismatch("unexpected result", 0, 1);
				else
					check_result(expected_q.pop_front());
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int rand_chars;
		dir_rows = '{
			'{"3+i2", NO_MID, "", 1'b1, '{61'sd3, 5'd0, 61'sd2, 5'd0, 1'b0}},
			'{"-.9999999999999999999", NO_MID, "", 1'b1,
				'{-61'sd999999999999999999, 5'd18, 61'sd0, 5'd0, 1'b1}},
			'{"", int'(CH_NUL), "", 1'b1, ZERO_RES},
			'{"", 255, "", 1'b1, ZERO_RES},
			'{"-1.5-i.25", NO_MID, "", 1'b0, ZERO_RES},
			'{"-i-2", NO_MID, "", 1'b0, ZERO_RES},
			'{"1..2x3", NO_MID, "", 1'b0, ZERO_RES},
			'{"12", int'(CH_NUL), "i5", 1'b0, ZERO_RES},
			'{"7-i", 128, "4", 1'b0, ZERO_RES},
			'{"+i+", NO_MID, "", 1'b0, ZERO_RES}
		};
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			txt_q.delete();
			for (int k = 0; k < dir_rows[r].head.len(); k++)
				txt_q.push_back(dir_rows[r].head[k]);
			if (dir_rows[r].mid != NO_MID)
				txt_q.push_back(CHAR_W'(dir_rows[r].mid));
			for (int k = 0; k < dir_rows[r].tail.len(); k++)
				txt_q.push_back(dir_rows[r].tail[k]);
			send_text(dir_rows[r].typed, dir_rows[r].want);
		end

		rand_chars = 0;
		while (rand_chars < RANDOM_CHARS) begin
			build_text();
			rand_chars += txt_q.size();
			send_text(1'b0, ZERO_RES);
		end
		char_valid <= 1'b0;
		draining = 1'b1;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results still pending", 0, expected_q.size());

		$display("sent %0d texts in %0d characters; checked %0d results, %0d with overflow",
			texts_sent, chars_sent, results_checked, ovf_results);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
